[rtl/arlp_pkg.sv]
// ----------------------------------------------------------------------------
// Readahead level policy package
// Shared widths, reset values and register indexes for the readahead block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arlp_pkg;

  // Field widths of the request and result items.
  localparam int LEVEL_W   = 4;
  localparam int LEN_W     = 32;
  localparam int BUF_W     = 40;
  localparam int BASE_W    = 25;
  localparam int WIN_W     = 48;
  localparam int RA_W      = 39;
  localparam int OUT_CNT_W = 32;

  // Default widths of the offset path and the read counters.
  localparam int OFFSET_BITS_DEF = 48;
  localparam int COUNT_BITS_DEF  = 32;

  // Largest readahead size: base shifted by two bits per level above one.
  localparam int SHIFT_W = LEVEL_W + 1;
  localparam int SIZE_W  = BASE_W + 2 * ((1 << LEVEL_W) - 2);

  // Divisor of the pressure threshold is twice the level.
  localparam int DIV_W = LEVEL_W + 1;

  // Result item layout.
  localparam int OUT_FIELDS_W = LEVEL_W + RA_W + 1 + 3 * OUT_CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = WIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL  = 2'd2;

  // Register values after reset.
  localparam logic [BASE_W-1:0]  BASE_SIZE_RST  = 25'd1048576;
  localparam logic [WIN_W-1:0]   SEQ_WINDOW_RST = 48'd2097152;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST  = 4'd4;

endpackage

[rtl/arlp_sadd.sv]
// ----------------------------------------------------------------------------
// Bit-serial adder cell
// Adds or subtracts two operands one bit per cycle while enabled, least significant first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arlp_sadd (
  input  logic clk,
  input  logic rst,
  input  logic clr,
  input  logic en,
  input  logic sub,
  input  logic a,
  input  logic b,
  output logic sum,
  output logic carry
);

  logic bx;

  // For subtraction the second operand is inverted and the carry starts at one.
  assign bx  = b ^ sub;
  assign sum = a ^ bx ^ carry;

  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= 1'b0;
    end else if (clr) begin
      carry <= sub;
    end else if (en) begin
      carry <= (a & bx) | (a & carry) | (bx & carry);
    end
  end

endmodule

[rtl/arlp_div.sv]
// ----------------------------------------------------------------------------
// Serial restoring divider
// Divides a wide dividend by a narrow divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arlp_div import arlp_pkg::*; #(
  parameter int N = BUF_W,
  parameter int D = DIV_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CntW = $clog2(N + 1);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [D-1:0]    rem;
  logic [D-1:0]    dvs;
  logic [D:0]      trial;
  logic            fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem, quotient[N-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(N);
      end else if (busy) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[N-2:0], fits};
      rem      <= fits ? D'(trial - {1'b0, dvs}) : trial[D-1:0];
    end
  end

endmodule

[rtl/adaptive_readahead_level_policy.sv]
// ----------------------------------------------------------------------------
// Adaptive readahead level policy: one result per read request.
// The bit-serial offset scan runs for every request; the threshold divider runs as well
// when the level after the scan is above one.
// One request at a time: a new request can be taken in the cycle in which the result appears.
// Synchronous reset restores the registers to their defaults and clears the state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_readahead_level_policy import arlp_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Fields from bit 0: read_offset, read_len, buffer_used, buffer_total.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [((OFFSET_BITS + LEN_W + 2 * BUF_W + 7) / 8) * 8 - 1:0] s_tdata,
  // Fields from bit 0: new_level, readahead_bytes, was_sequential,
  // total_reads, sequential_reads, random_reads.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ScanBits = (OFFSET_BITS + 1 > SIZE_W) ? OFFSET_BITS + 1 : SIZE_W;
  localparam int CntW     = $clog2(ScanBits);
  localparam int LenLo    = OFFSET_BITS;
  localparam int UsedLo   = OFFSET_BITS + LEN_W;
  localparam int TotalLo  = OFFSET_BITS + LEN_W + BUF_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]             state;
  logic [CntW-1:0]        cnt;

  // Configuration registers.
  logic [BASE_W-1:0]      base_size;
  logic [WIN_W-1:0]       seq_window;
  logic [LEVEL_W-1:0]     max_level;

  // Policy state.
  logic [LEVEL_W-1:0]     cur_level;
  logic [OFFSET_BITS-1:0] seq_bytes;
  logic [OFFSET_BITS-1:0] prev_offset;
  logic [COUNT_BITS-1:0]  count_all;
  logic [COUNT_BITS-1:0]  count_seq;
  logic [COUNT_BITS-1:0]  count_rand;

  // Operand shift registers and per-request flags.
  logic [OFFSET_BITS-1:0] off_sr;
  logic [LEN_W-1:0]       len_sr;
  logic [WIN_W-1:0]       win_sr;
  logic [BASE_W-1:0]      base_sr;
  logic [BUF_W-1:0]       used_r;
  logic [BUF_W-1:0]       total_r;
  logic                   neq;
  logic                   nz;
  logic                   size_hi;
  logic                   ovf;
  logic                   was_seq;
  logic                   press_chk;

  // Serial bit streams.
  logic                   lo;
  logic                   off_b;
  logic                   prev_b;
  logic                   seq_b;
  logic [SHIFT_W-1:0]     sh;
  logic                   size_on;
  logic                   size_b;
  logic                   d1_s;
  logic                   d1_c;
  logic                   d2_s;
  logic                   c1_c;
  logic                   c2_c;
  logic                   sq_s;
  logic                   np_s;
  logic                   ge_c;
  logic                   accept;

  // Decision after the scan.
  logic                   in_win;
  logic                   ge;
  logic [OFFSET_BITS-1:0] seq_sat;
  logic [LEVEL_W-1:0]     lvl_d;
  logic [OFFSET_BITS-1:0] seq_d;
  logic                   zeroed;

  // Pressure check and result.
  logic                   div_start;
  logic                   div_done;
  logic [BUF_W-1:0]       quot;
  logic [BUF_W:0]         thr;
  logic                   pressure;
  logic [LEVEL_W-1:0]     lvl_f;
  logic [SHIFT_W-1:0]     sh_f;
  logic [SIZE_W-1:0]      size_f;
  logic [RA_W-1:0]        ra_f;
  logic                   out_free;
  logic [OUT_CNT_W-1:0]   all_o;
  logic [OUT_CNT_W-1:0]   seq_o;
  logic [OUT_CNT_W-1:0]   rand_o;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_size  <= BASE_SIZE_RST;
      seq_window <= SEQ_WINDOW_RST;
      max_level  <= MAX_LEVEL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_SIZE:  base_size  <= cfg_data[BASE_W-1:0];
        REG_SEQ_WINDOW: seq_window <= cfg_data[WIN_W-1:0];
        REG_MAX_LEVEL:  max_level  <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Bit streams fed to the serial cells, least significant bit first.
  assign lo      = cnt < CntW'(OFFSET_BITS);
  assign off_b   = off_sr[0];
  assign prev_b  = lo & prev_offset[0];
  assign seq_b   = lo & seq_bytes[0];
  assign sh      = {LEVEL_W'(cur_level - LEVEL_W'(1)), 1'b0};
  assign size_on = (cur_level != '0) && (cnt >= CntW'(sh));
  assign size_b  = size_on & base_sr[0];

  // Offset distance in both directions, each compared with the window.
  arlp_sadd u_d1 (
    .clk(clk), .rst(rst), .clr(accept), .en(state == ST_SCAN), .sub(1'b1),
    .a(off_b), .b(prev_b), .sum(d1_s), .carry(d1_c)
  );
  arlp_sadd u_d2 (
    .clk(clk), .rst(rst), .clr(accept), .en(state == ST_SCAN), .sub(1'b1),
    .a(prev_b), .b(off_b), .sum(d2_s), .carry()
  );
  arlp_sadd u_c1 (
    .clk(clk), .rst(rst), .clr(accept), .en(state == ST_SCAN), .sub(1'b1),
    .a(win_sr[0]), .b(d1_s), .sum(), .carry(c1_c)
  );
  arlp_sadd u_c2 (
    .clk(clk), .rst(rst), .clr(accept), .en(state == ST_SCAN), .sub(1'b1),
    .a(win_sr[0]), .b(d2_s), .sum(), .carry(c2_c)
  );

  // Sequential byte count plus length, and the offset after the read.
  arlp_sadd u_sq (
    .clk(clk), .rst(rst), .clr(accept), .en(state == ST_SCAN), .sub(1'b0),
    .a(seq_b), .b(len_sr[0]), .sum(sq_s), .carry()
  );
  arlp_sadd u_np (
    .clk(clk), .rst(rst), .clr(accept), .en(state == ST_SCAN), .sub(1'b0),
    .a(off_b), .b(len_sr[0]), .sum(np_s), .carry()
  );

  // Updated byte count against the readahead size of the current level.
  arlp_sadd u_ge (
    .clk(clk), .rst(rst), .clr(accept), .en(state == ST_SCAN), .sub(1'b1),
    .a(sq_s), .b(size_b), .sum(), .carry(ge_c)
  );

  // Level decision once every bit has been scanned.
  always_comb begin
    in_win  = d1_c ? c1_c : c2_c;
    seq_sat = ovf ? '1 : seq_bytes;
    ge      = ovf ? !size_hi : ge_c;
    lvl_d   = cur_level;
    seq_d   = in_win ? seq_sat : '0;
    zeroed  = 1'b0;
    if (!neq) begin
      if (!nz) begin
        lvl_d = LEVEL_W'(1);
        seq_d = '0;
      end else if ((cur_level < max_level) && ge) begin
        lvl_d = cur_level + LEVEL_W'(1);
        seq_d = '0;
      end
    end else if (!in_win) begin
      if (cur_level != '0) begin
        lvl_d  = cur_level - LEVEL_W'(1);
        zeroed = (cur_level == LEVEL_W'(1));
      end
      seq_d = '0;
    end
  end

  assign div_start = (state == ST_DECIDE) && (lvl_d > LEVEL_W'(1));

  // Quotient of buffer_total by twice the level.
  arlp_div #(
    .N(BUF_W),
    .D(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total_r),
    .divisor  ({lvl_d, 1'b0}),
    .done     (div_done),
    .quotient (quot)
  );

  // Buffer pressure and the readahead size of the final level.
  always_comb begin
    thr      = {2'b00, total_r[BUF_W-1:1]} + {1'b0, quot};
    pressure = press_chk && ({1'b0, used_r} > thr);
    lvl_f    = pressure ? cur_level - LEVEL_W'(1) : cur_level;
    sh_f     = {LEVEL_W'(lvl_f - LEVEL_W'(1)), 1'b0};
    size_f   = (lvl_f == '0) ? '0 : (SIZE_W'(base_size) << sh_f);
    ra_f     = (|size_f[SIZE_W-1:RA_W]) ? '1 : size_f[RA_W-1:0];
  end

  // Counters leave through the fixed result width.
  generate
    if (COUNT_BITS >= OUT_CNT_W) begin : g_cnt_trunc
      assign all_o  = count_all[OUT_CNT_W-1:0];
      assign seq_o  = count_seq[OUT_CNT_W-1:0];
      assign rand_o = count_rand[OUT_CNT_W-1:0];
    end else begin : g_cnt_ext
      assign all_o  = {{(OUT_CNT_W - COUNT_BITS){1'b0}}, count_all};
      assign seq_o  = {{(OUT_CNT_W - COUNT_BITS){1'b0}}, count_seq};
      assign rand_o = {{(OUT_CNT_W - COUNT_BITS){1'b0}}, count_rand};
    end
  endgenerate

  // Sequencer and policy state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      cur_level   <= '0;
      seq_bytes   <= '0;
      prev_offset <= '0;
      count_all   <= '0;
      count_seq   <= '0;
      count_rand  <= '0;
      m_tvalid    <= 1'b0;
      press_chk   <= 1'b0;
    end else begin
      // A new result may replace one that leaves in the same cycle.
      if ((state == ST_FINISH) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cnt   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (lo) begin
            prev_offset <= {np_s, prev_offset[OFFSET_BITS-1:1]};
            seq_bytes   <= {sq_s, seq_bytes[OFFSET_BITS-1:1]};
          end
          cnt <= cnt + CntW'(1);
          if (cnt == CntW'(ScanBits - 1)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          cur_level <= lvl_d;
          seq_bytes <= seq_d;
          if (zeroed) begin
            prev_offset <= '0;
          end
          count_all <= count_all + COUNT_BITS'(1);
          if (in_win) begin
            count_seq <= count_seq + COUNT_BITS'(1);
          end else begin
            count_rand <= count_rand + COUNT_BITS'(1);
          end
          press_chk <= div_start;
          state     <= div_start ? ST_DIV : ST_FINISH;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            cur_level <= lvl_f;
            if (pressure) begin
              seq_bytes <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Operand shift registers and scan flags.
  always_ff @(posedge clk) begin
    if (accept) begin
      off_sr  <= s_tdata[OFFSET_BITS-1:0];
      len_sr  <= s_tdata[LenLo +: LEN_W];
      used_r  <= s_tdata[UsedLo +: BUF_W];
      total_r <= s_tdata[TotalLo +: BUF_W];
      win_sr  <= seq_window;
      base_sr <= base_size;
      neq     <= 1'b0;
      nz      <= 1'b0;
      size_hi <= 1'b0;
      ovf     <= 1'b0;
    end else if (state == ST_SCAN) begin
      off_sr <= {1'b0, off_sr[OFFSET_BITS-1:1]};
      len_sr <= {1'b0, len_sr[LEN_W-1:1]};
      win_sr <= {1'b0, win_sr[WIN_W-1:1]};
      neq    <= neq | (off_b ^ prev_b);
      nz     <= nz | off_b;
      if (size_on) begin
        base_sr <= {1'b0, base_sr[BASE_W-1:1]};
      end
      if (size_b && !lo) begin
        size_hi <= 1'b1;
      end
      if (cnt == CntW'(OFFSET_BITS)) begin
        ovf <= sq_s;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == ST_DECIDE) begin
      was_seq <= in_win;
    end
    if ((state == ST_FINISH) && out_free) begin
      m_tdata <= OUT_DATA_W'({rand_o, seq_o, all_o, was_seq, ra_f, lvl_f});
    end
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Readahead level policy testbench
// Streams file read requests into the policy block and checks every result
// against a cycle-free predictor of the level, the readahead size and the
// read counters. The register settings are changed between idle phases.
// Both stream sides idle at random, and the receiver holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import arlp_pkg::*;

  localparam int OFS_W       = OFFSET_BITS_DEF;
  localparam int S_DATA_W    = ((OFS_W + LEN_W + 2 * BUF_W + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 120;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_READS = 75;

  // Predicts the level and counters after each accepted read request.
  class level_policy_model;
    typedef struct {
      logic [LEVEL_W-1:0]   level;
      logic [RA_W-1:0]      ra_bytes;
      logic                 seq_hit;
      logic [OUT_CNT_W-1:0] n_all;
      logic [OUT_CNT_W-1:0] n_seq;
      logic [OUT_CNT_W-1:0] n_rand;
    } level_result_t;

    logic [BASE_W-1:0]    base_size;
    logic [WIN_W-1:0]     window;
    logic [LEVEL_W-1:0]   level_cap;
    logic [LEVEL_W-1:0]   level;
    logic [OFS_W-1:0]     seq_bytes;
    logic [OFS_W-1:0]     last_off;
    logic [OUT_CNT_W-1:0] n_all;
    logic [OUT_CNT_W-1:0] n_seq;
    logic [OUT_CNT_W-1:0] n_rand;
    level_result_t        expected_levels[$];
    int                   mismatches;

    function new();
      base_size  = BASE_SIZE_RST;
      window     = SEQ_WINDOW_RST;
      level_cap  = MAX_LEVEL_RST;
      level      = '0;
      seq_bytes  = '0;
      last_off   = '0;
      n_all      = '0;
      n_seq      = '0;
      n_rand     = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BASE_SIZE:  base_size = data[BASE_W-1:0];
        REG_SEQ_WINDOW: window = data[WIN_W-1:0];
        REG_MAX_LEVEL:  level_cap = data[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    // Readahead size at a level: base times four per level above one.
    function logic [63:0] size_of(logic [LEVEL_W-1:0] lvl);
      if (lvl == 0) return 64'd0;
      return 64'(base_size) << (2 * (int'(lvl) - 1));
    endfunction

    // Lowers the level by one; reports whether it just reached zero.
    function bit step_down();
      if (level > 0) begin
        level--;
        seq_bytes = '0;
        return level == 0;
      end
      return 1'b0;
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    function void note_read(logic [OFS_W-1:0] off, logic [LEN_W-1:0] len,
                            logic [BUF_W-1:0] used, logic [BUF_W-1:0] total);
      logic [OFS_W-1:0] gap_dist;
      logic [63:0]      thr;
      logic [63:0]      sz;
      bit               in_win;
      bit               zeroed;
      level_result_t    r;
      gap_dist = (off >= last_off) ? off - last_off : last_off - off;
      in_win   = gap_dist <= window;
      zeroed   = 1'b0;

      // Counters wrap; the sequential byte count saturates.
      n_all++;
      if (in_win) begin
        seq_bytes = (len > ({OFS_W{1'b1}} - seq_bytes)) ? {OFS_W{1'b1}} : seq_bytes + len;
        n_seq++;
      end else begin
        n_rand++;
      end

      // A read at the last offset starts or promotes; a far jump demotes.
      if (off == last_off) begin
        if (off == 0) begin
          level     = LEVEL_W'(1);
          seq_bytes = '0;
        end else if (level < level_cap && 64'(seq_bytes) >= size_of(level)) begin
          level++;
          seq_bytes = '0;
        end
      end else if (!in_win) begin
        if (step_down()) zeroed = 1'b1;
        seq_bytes = '0;
      end

      // Buffer pressure demotes once more above level one.
      if (level > 1) begin
        thr = 64'(total) / 2 + 64'(total) / (64'(level) * 2);
        if (64'(used) > thr && step_down()) zeroed = 1'b1;
      end

      last_off = zeroed ? '0 : off + len;

      sz         = size_of(level);
      r.level    = level;
      r.ra_bytes = (sz > 64'({RA_W{1'b1}})) ? {RA_W{1'b1}} : sz[RA_W-1:0];
      r.seq_hit  = in_win;
      r.n_all    = n_all;
      r.n_seq    = n_seq;
      r.n_rand   = n_rand;
      expected_levels.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_level(logic [OUT_DATA_W-1:0] d);
      level_result_t e;
      if (expected_levels.size() == 0) begin
        $error("result with no read outstanding: %h", d);
        mismatches++;
        return;
      end
      e = expected_levels.pop_front();
      compare("new_level", e.level, d[LEVEL_W-1:0]);
      compare("readahead_bytes", e.ra_bytes, d[LEVEL_W +: RA_W]);
      compare("was_sequential", e.seq_hit, d[LEVEL_W + RA_W]);
      compare("total_reads", e.n_all, d[LEVEL_W + RA_W + 1 +: OUT_CNT_W]);
      compare("sequential_reads", e.n_seq, d[LEVEL_W + RA_W + 1 + OUT_CNT_W +: OUT_CNT_W]);
      compare("random_reads", e.n_rand, d[LEVEL_W + RA_W + 1 + 2 * OUT_CNT_W +: OUT_CNT_W]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  level_policy_model model;
  bit                hold_req;
  int                idle_cycles;

  adaptive_readahead_level_policy dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int idle_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  function automatic logic [BUF_W-1:0] rand40();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[BUF_W-1:0];
  endfunction

  // Offers one read request and returns once it has been taken.
  task automatic send_read(input logic [OFS_W-1:0] off, input logic [LEN_W-1:0] len,
                           input logic [BUF_W-1:0] used, input logic [BUF_W-1:0] total);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'({total, used, len, off});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model.note_read(off, len, used, total);
    gap = idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every result is back, then writes all three registers.
  task automatic write_regs(input logic [BASE_W-1:0] base, input logic [WIN_W-1:0] win,
                            input logic [LEVEL_W-1:0] cap);
    logic [CFG_IDX_W-1:0]  idxs[3];
    logic [CFG_DATA_W-1:0] vals[3];
    s_tvalid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    idxs[0] = REG_BASE_SIZE;
    idxs[1] = REG_SEQ_WINDOW;
    idxs[2] = REG_MAX_LEVEL;
    vals[0] = CFG_DATA_W'(base);
    vals[1] = CFG_DATA_W'(win);
    vals[2] = CFG_DATA_W'(cap);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      model.set_reg(idxs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly reads that continue the stream, with restarts, near and far
  // jumps and fully random requests mixed in.
  task automatic random_read();
    logic [OFS_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic [BUF_W-1:0]  used;
    logic [BUF_W-1:0]  total;
    logic [63:0]       d;
    int                kind;
    int                pick;
    kind  = $urandom_range(0, 99);
    pick  = $urandom_range(0, 99);
    total = rand40();
    if ($urandom_range(0, 99) < 20) used = rand40();
    else used = BUF_W'(64'(rand40()) % (64'(total) / 2 + 1));
    if (pick < 40) len = $urandom();
    else if (pick < 70) len = $urandom_range(0, 65535);
    else if (pick < 80) len = '1;
    else if (pick < 85) len = '0;
    else len = $urandom_range(1 << 20, 1 << 24);

    if (kind < 55) begin
      off = model.last_off;
    end else if (kind < 65) begin
      off = '0;
    end else if (kind < 80) begin
      d   = {$urandom(), $urandom()};
      d   = d % (64'(model.window) + 1);
      off = $urandom_range(0, 1) ? model.last_off + d[OFS_W-1:0]
                                 : model.last_off - d[OFS_W-1:0];
    end else if (kind < 90) begin
      off = rand48();
    end else begin
      off   = rand48();
      len   = $urandom();
      used  = rand40();
      total = rand40();
    end
    send_read(off, len, used, total);
  endtask

  // Result side: random ready with gaps, and one long hold-off on request.
  initial begin : result_sink
    int run_len;
    int gap;
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      run_len = $urandom_range(1, 40);
      m_tready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = idle_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) model.check_level(m_tdata);
  end

  // Ends the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [BASE_W-1:0]  base;
    logic [WIN_W-1:0]   win;
    logic [LEVEL_W-1:0] cap;
    model       = new();
    hold_req    = 1'b0;
    idle_cycles = 0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: level zero with a matching nonzero offset promotes,
    // a full-length read promotes again, zero buffer total demotes, the
    // offset wraps, and far jumps walk the level back down to zero.
    send_read(48'd5000, 32'd100, '0, '0);
    send_read(model.last_off, '0, '0, '0);
    send_read(model.last_off, '1, '0, '1);
    send_read(model.last_off, 32'd1 << 22, 40'd1, '0);
    send_read('1, 32'h1000, '0, '0);
    send_read(model.last_off, '1, '0, 40'd1 << 30);
    send_read(48'h8000_0000_0000, 32'd64, '1, '1);
    send_read(48'h1234, 32'd64, '0, '0);
    send_read('0, 32'd4096, '0, '0);

    // Zero base, zero window, no promotion: offset zero still starts level one.
    write_regs('0, '0, '0);
    send_read('0, 32'd10, '0, '0);
    send_read('0, 32'd10, '0, '0);
    send_read(model.last_off, '1, '0, '0);
    send_read(model.last_off + 1, 32'd5, '0, '0);

    // Smallest base and widest window: climb one level per read up to fifteen.
    write_regs(25'd1, '1, '1);
    send_read('0, '1, '0, '1);
    for (int i = 0; i < 14; i++) send_read(model.last_off, '1, '0, '1);

    // Largest base at the top level: the readahead size saturates, then
    // full buffer use demotes.
    write_regs('1, '1, '1);
    send_read(model.last_off, '0, '0, '1);
    send_read(model.last_off, 32'd7, '1, '1);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin base = BASE_SIZE_RST; win = SEQ_WINDOW_RST; cap = MAX_LEVEL_RST; end
        1: begin
          base = BASE_W'($urandom_range(1, 1 << 24));
          win  = rand48();
          cap  = LEVEL_W'($urandom_range(1, 8));
        end
        2: begin base = 25'd1 << 24; win = '1; cap = 4'd8; end
        3: begin base = 25'd1; win = '0; cap = '1; end
        4: begin
          base = BASE_W'($urandom());
          win  = $urandom_range(0, 1) ? rand48() : WIN_W'($urandom_range(0, 1 << 22));
          cap  = LEVEL_W'($urandom_range(0, 15));
        end
        default: begin base = 25'd4096; win = 48'd1 << 20; cap = 4'd1; end
      endcase
      write_regs(base, win, cap);
      for (int i = 0; i < PHASE_READS; i++) begin
        if (ph == 2 && i == 30) hold_req = 1'b1;
        random_read();
      end
    end

    s_tvalid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (model.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
